[rtl/ags_pkg.sv]
// ags_pkg: shared types, codes and constants for the ADC group result sequencer.
// No dependencies; used by every other file of the block.
package ags_pkg;

  localparam int unsigned MaxStreamSamples = 64;
  localparam int unsigned MaxChannels      = 8;
  localparam int unsigned SampleBits       = 12;

  localparam int unsigned ReqW   = 2;
  localparam int unsigned SmpW   = 12;
  localparam int unsigned AddrW  = 9;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CcW    = 4;
  localparam int unsigned SsW    = 7;
  localparam int unsigned IdxW   = 7;
  localparam int unsigned PosW   = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 7;

  localparam logic [SmpW-1:0] SampleMask = SmpW'((32'd1 << SampleBits) - 32'd1);

  typedef enum logic [ReqW-1:0] {
    REQ_START  = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_STOP   = 2'd2
  } req_e;

  typedef enum logic [StatW-1:0] {
    ST_IDLE        = 2'd0,
    ST_BUSY        = 2'd1,
    ST_DONE        = 2'd2,
    ST_STREAM_DONE = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHANNEL_COUNT  = 3'd0,
    CFG_STREAMING_MODE = 3'd1,
    CFG_STREAM_SAMPLES = 3'd2,
    CFG_CIRCULAR       = 3'd3,
    CFG_CONTINUOUS     = 3'd4,
    CFG_NOTIFY_ENABLE  = 3'd5,
    CFG_SW_TRIGGER     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic              write_valid;
    logic [AddrW-1:0]  write_addr;
    logic [SmpW-1:0]   write_data;
    logic              round_done;
    status_e           group_status;
    logic              retrigger;
    logic              deactivate;
    logic              notify;
    logic              rejected;
  } res_t;

endpackage

[rtl/ags_if.sv]
// ags_req_if / ags_res_if: valid/ready channels for request and result beats.
// Depends on ags_pkg for field widths.
interface ags_req_if;
  logic                     valid;
  logic                     ready;
  logic [ags_pkg::ReqW-1:0] req_type;
  logic [ags_pkg::SmpW-1:0] sample_value;

  modport source (output valid, output req_type, output sample_value, input ready);
  modport sink   (input valid, input req_type, input sample_value, output ready);
endinterface

interface ags_res_if;
  logic                      valid;
  logic                      ready;
  logic                      write_valid;
  logic [ags_pkg::AddrW-1:0] write_addr;
  logic [ags_pkg::SmpW-1:0]  write_data;
  logic                      round_done;
  logic [ags_pkg::StatW-1:0] group_status;
  logic                      retrigger;
  logic                      deactivate;
  logic                      notify;
  logic                      rejected;

  modport source (output valid, output write_valid, output write_addr, output write_data,
                  output round_done, output group_status, output retrigger,
                  output deactivate, output notify, output rejected, input ready);
  modport sink   (input valid, input write_valid, input write_addr, input write_data,
                  input round_done, input group_status, input retrigger,
                  input deactivate, input notify, input rejected, output ready);
endinterface

[rtl/adc_group_result_sequencer.sv]
// adc_group_result_sequencer: top level of one ADC conversion-group sequencer.
// Depends on ags_pkg, ags_if, ags_core and ags_out_buf.
//
// Usage: the request channel (req_i) carries one beat per start, stop or
// converted sample. Every accepted beat yields exactly one result beat on
// res_o: the buffer write (address and data), round completion, the group
// status after the beat, and the retrigger / deactivate / notify / rejected
// pulses. Configuration is a plain write port (cfg_we_i, cfg_idx_i,
// cfg_wdata_i); write it only while no result is outstanding.
//
// The result of a beat is registered in the result queue and reaches res_o
// once older entries pop. One beat per cycle while the queue has space; group
// state and address arithmetic (one 7x4 multiply and add) settle on accept.
// Reset clears the group to idle, index and round position to zero, and the
// registers to their defaults (one channel, software trigger).
// When the receiver stalls, a two-entry result queue keeps taking beats until
// both entries are full; then req_i.ready drops and holds until a pop.
module adc_group_result_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ags_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ags_pkg::CfgDataW-1:0]  cfg_wdata_i,
  ags_req_if.sink                       req_i,
  ags_res_if.source                     res_o
);
  import ags_pkg::*;

  logic accept;
  logic space;
  logic pop;
  res_t res_new;
  res_t res_head;

  assign req_i.ready = space;
  assign accept      = req_i.valid && space;
  assign pop         = res_o.valid && res_o.ready;

  ags_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (accept),
    .req_type_i     (req_i.req_type),
    .sample_value_i (req_i.sample_value),
    .res_o          (res_new)
  );

  ags_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res_new),
    .space_o (space),
    .valid_o (res_o.valid),
    .pop_i   (pop),
    .data_o  (res_head)
  );

  // Unpack the head entry onto the result channel.
  assign res_o.write_valid  = res_head.write_valid;
  assign res_o.write_addr   = res_head.write_addr;
  assign res_o.write_data   = res_head.write_data;
  assign res_o.round_done   = res_head.round_done;
  assign res_o.group_status = res_head.group_status;
  assign res_o.retrigger    = res_head.retrigger;
  assign res_o.deactivate   = res_head.deactivate;
  assign res_o.notify       = res_head.notify;
  assign res_o.rejected     = res_head.rejected;

endmodule

[rtl/ags_core.sv]
// ags_core: configuration registers, group state and the per-beat result logic.
// Depends on ags_pkg.
module ags_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ags_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ags_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          accept_i,
  input  logic [ags_pkg::ReqW-1:0]      req_type_i,
  input  logic [ags_pkg::SmpW-1:0]      sample_value_i,
  output ags_pkg::res_t                 res_o
);
  import ags_pkg::*;

  logic [CcW-1:0] channel_count_q;
  logic           streaming_mode_q;
  logic [SsW-1:0] stream_samples_q;
  logic           continuous_q;
  logic           notify_enable_q;
  logic           sw_trigger_q;

  status_e         status_q, status_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [PosW-1:0] pos_q, pos_d;

  logic [CcW-1:0]   cc;
  logic [SsW-1:0]   ss;
  logic [SsW-1:0]   total;
  logic [IdxW-1:0]  slot;
  logic [IdxW-1:0]  idx_inc;
  logic             round_end;
  logic             oneshot;
  res_t             res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_count_q  <= CcW'(1);
      streaming_mode_q <= 1'b0;
      stream_samples_q <= '0;
      continuous_q     <= 1'b0;
      notify_enable_q  <= 1'b0;
      sw_trigger_q     <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CHANNEL_COUNT:  channel_count_q  <= cfg_wdata_i[CcW-1:0];
        CFG_STREAMING_MODE: streaming_mode_q <= cfg_wdata_i[0];
        CFG_STREAM_SAMPLES: stream_samples_q <= cfg_wdata_i[SsW-1:0];
        // Buffer mode never changes the address, so drop the write.
        CFG_CIRCULAR:       ;
        CFG_CONTINUOUS:     continuous_q     <= cfg_wdata_i[0];
        CFG_NOTIFY_ENABLE:  notify_enable_q  <= cfg_wdata_i[0];
        CFG_SW_TRIGGER:     sw_trigger_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_IDLE;
      idx_q    <= '0;
      pos_q    <= '0;
    end else if (accept_i) begin
      status_q <= status_d;
      idx_q    <= idx_d;
      pos_q    <= pos_d;
    end
  end

  always_comb begin
    // Clamp the configured counts into their usable range.
    cc = channel_count_q;
    if (cc == '0) cc = CcW'(1);
    if (cc > CcW'(MaxChannels)) cc = CcW'(MaxChannels);
    ss = (stream_samples_q > SsW'(MaxStreamSamples)) ? SsW'(MaxStreamSamples)
                                                     : stream_samples_q;
    total   = (ss == '0) ? SsW'(1) : ss;
    // Linear and circular buffers agree here: the slot is clamped below total.
    slot    = '0;
    if (streaming_mode_q) slot = (idx_q < total) ? idx_q : (total - SsW'(1));
    idx_inc   = (idx_q != '1) ? idx_q + IdxW'(1) : idx_q;
    round_end = ({1'b0, pos_q} + CcW'(1)) >= cc;
    oneshot   = !continuous_q;

    status_d = status_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    res      = '0;

    case (req_type_i)
      REQ_START: begin
        if (status_q == ST_BUSY) begin
          res.rejected = 1'b1;
        end else begin
          idx_d         = '0;
          pos_d         = '0;
          status_d      = ST_BUSY;
          res.retrigger = sw_trigger_q;
        end
      end
      REQ_STOP: begin
        status_d       = ST_IDLE;
        pos_d          = '0;
        res.deactivate = 1'b1;
      end
      REQ_SAMPLE: begin
        if (status_q == ST_BUSY) begin
          res.write_valid = 1'b1;
          res.write_addr  = AddrW'(AddrW'(slot) * AddrW'(cc)) + AddrW'(pos_q);
          res.write_data  = sample_value_i & SampleMask;
          if (round_end) begin
            res.round_done = 1'b1;
            res.notify     = notify_enable_q;
            pos_d          = '0;
            if (streaming_mode_q) begin
              idx_d = idx_inc;
              if (ss != '0 && idx_inc >= ss) begin
                status_d       = ST_STREAM_DONE;
                res.deactivate = oneshot;
              end else begin
                status_d      = ST_BUSY;
                res.retrigger = oneshot;
              end
            end else if (!oneshot) begin
              status_d      = ST_BUSY;
              res.retrigger = 1'b1;
            end else begin
              status_d       = ST_DONE;
              res.deactivate = 1'b1;
            end
          end else begin
            pos_d = pos_q + PosW'(1);
          end
        end
      end
      default: ;
    endcase
    res.group_status = status_d;
  end

  assign res_o = res;

endmodule

[rtl/ags_out_buf.sv]
// ags_out_buf: two-entry result queue between the core and the result channel.
// Depends on ags_pkg for the result struct.
module ags_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ags_pkg::res_t data_i,
  output logic          space_o,
  output logic          valid_o,
  input  logic          pop_i,
  output ags_pkg::res_t data_o
);
  import ags_pkg::*;

  res_t       head_q, tail_q;
  logic [1:0] count_q, count_d;

  assign space_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = head_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 2'd1;
    if (!push_i && pop_i) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else         count_q <= count_d;
  end

  // Payload needs no reset: valid follows the count.
  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      if (count_q == 2'd2) begin
        head_q <= tail_q;
        if (push_i) tail_q <= data_i;
      end else if (push_i) begin
        head_q <= data_i;
      end
    end else if (push_i) begin
      if (count_q == 2'd0) head_q <= data_i;
      else                 tail_q <= data_i;
    end
  end

endmodule
